>>> rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

  localparam int HalfPeriodW = 8;
  localparam int PollW       = 16;
  localparam int StepW       = 5;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 16;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;
  localparam logic [2:0] KIND_ACK   = 3'd5;

  localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_POLL_LIMIT  = 1'd1;

  localparam logic [HalfPeriodW-1:0] HALF_PERIOD_RST = 8'd5;
  localparam logic [PollW-1:0]       POLL_LIMIT_RST  = 16'd1000;

  // result of one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_value;
    logic       sda_drive;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_done;
    logic       ack_received;
    logic       ack_timeout;
    logic       command_dropped;
  } res_t;

  function automatic logic [StepW-1:0] phase_total(input logic [2:0] cmd);
    case (cmd)
      KIND_START: phase_total = 5'd4;
      KIND_STOP:  phase_total = 5'd4;
      KIND_WRITE: phase_total = 5'd18;
      KIND_READ:  phase_total = 5'd18;
      KIND_ACK:   phase_total = 5'd3;
      default:    phase_total = 5'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/i2cm_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cm_seq (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           advance_en,
  input  wire logic [2:0]                     kind,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           sda_level,
  input  wire logic [i2cm_pkg::HalfPeriodW-1:0] half_period,
  input  wire logic [i2cm_pkg::PollW-1:0]       poll_limit,
  output i2cm_pkg::res_t                      res
);
  import i2cm_pkg::*;

  logic [StepW-1:0]       step_r, step_nxt;
  logic [HalfPeriodW-1:0] timer_r, timer_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [PollW-1:0]       poll_r, poll_nxt;
  logic [2:0]             cmd_r, cmd_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   drv_r, drv_nxt;
  logic [7:0]             last_r, last_nxt;

  logic [HalfPeriodW-1:0] hold;
  logic [PollW-1:0]       limit;
  logic                   start_new;
  logic                   adv;
  logic                   done, ack, tmo, dropped, busy;
  logic [StepW-1:0]       s;

  assign hold  = (half_period == '0) ? HalfPeriodW'(1) : half_period;
  assign limit = (poll_limit == '0) ? PollW'(1) : poll_limit;
  assign start_new = (cmd_r == KIND_NONE) && (kind >= KIND_START) && (kind <= KIND_ACK);

  always_comb begin
    cmd_nxt   = cmd_r;
    step_nxt  = step_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    last_nxt  = last_r;
    done      = 1'b0;
    ack       = 1'b0;
    tmo       = 1'b0;
    busy      = 1'b0;
    adv       = 1'b0;
    dropped   = (cmd_r != KIND_NONE) && (kind != KIND_NONE);

    if (start_new) begin
      cmd_nxt   = kind;
      step_nxt  = '0;
      timer_nxt = '0;
      shift_nxt = (kind == KIND_WRITE) ? data_byte : 8'd0;
      poll_nxt  = '0;
    end
    s = step_nxt;

    if (cmd_nxt != KIND_NONE) begin
      busy = 1'b1;
      // pin changes on the first tick of a phase
      if (timer_nxt == '0) begin
        case (cmd_nxt)
          KIND_START: begin
            if (s == 5'd0) begin
              drv_nxt = 1'b1;
              sda_nxt = 1'b1;
            end else if (s == 5'd1) scl_nxt = 1'b1;
            else if (s == 5'd2) sda_nxt = 1'b0;
            else scl_nxt = 1'b0;
          end
          KIND_STOP: begin
            if (s == 5'd0) begin
              drv_nxt = 1'b1;
              sda_nxt = 1'b0;
            end else if (s == 5'd1) scl_nxt = 1'b1;
            else if (s == 5'd2) sda_nxt = 1'b1;
            else scl_nxt = 1'b0;
          end
          KIND_WRITE: begin
            if (s < 5'd16) begin
              if (s == 5'd0) drv_nxt = 1'b1;
              if (!s[0]) scl_nxt = 1'b0;
              else begin
                sda_nxt = shift_nxt[7];
                scl_nxt = 1'b1;
              end
            end else if (s == 5'd16) scl_nxt = 1'b0;
            else sda_nxt = 1'b1;
          end
          KIND_READ: begin
            if (s == 5'd0) scl_nxt = 1'b0;
            else if (s == 5'd1) sda_nxt = 1'b1;
            else if (!s[0]) begin
              scl_nxt = 1'b1;
              drv_nxt = 1'b0;
            end else scl_nxt = 1'b0;
          end
          KIND_ACK: begin
            if (s == 5'd0) scl_nxt = 1'b1;
            else if (s == 5'd1) drv_nxt = 1'b0;
            else scl_nxt = 1'b0;
          end
          default: ;
        endcase
      end

      if (cmd_nxt == KIND_ACK && s == 5'd1) begin
        if (!sda_level) begin
          ack = 1'b1;
          adv = 1'b1;
        end else begin
          poll_nxt = poll_nxt + PollW'(1);
          if (poll_nxt >= limit || poll_nxt == '0) begin
            tmo = 1'b1;
            adv = 1'b1;
          end
        end
      end else begin
        timer_nxt = timer_nxt + HalfPeriodW'(1);
        if (timer_nxt >= hold) begin
          adv = 1'b1;
          if (cmd_nxt == KIND_WRITE && s < 5'd16 && s[0])
            shift_nxt = {shift_nxt[6:0], 1'b0};
          if (cmd_nxt == KIND_READ && s >= 5'd2 && !s[0])
            shift_nxt = {shift_nxt[6:0], sda_level};
        end
      end

      if (adv) begin
        timer_nxt = '0;
        step_nxt  = s + StepW'(1);
        if (step_nxt >= phase_total(cmd_nxt)) begin
          if (cmd_nxt == KIND_READ) begin
            last_nxt = shift_nxt;
            done     = 1'b1;
          end
          cmd_nxt  = KIND_NONE;
          step_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= KIND_NONE;
      step_r  <= '0;
      timer_r <= '0;
      shift_r <= '0;
      poll_r  <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      drv_r   <= 1'b0;
      last_r  <= '0;
    end else if (advance_en) begin
      cmd_r   <= cmd_nxt;
      step_r  <= step_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
      poll_r  <= poll_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drv_r   <= drv_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    res.scl_level       = scl_nxt;
    res.sda_value       = sda_nxt;
    res.sda_drive       = drv_nxt;
    res.busy_res        = busy;
    res.read_data       = last_nxt;
    res.read_done       = done;
    res.ack_received    = ack;
    res.ack_timeout     = tmo;
    res.command_dropped = dropped;
  end

endmodule
`default_nettype wire

>>> rtl/i2cm_out.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cm_out (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire i2cm_pkg::res_t res_in,
  input  wire logic           out_stall,
  output logic                out_valid,
  output logic                can_load,
  output i2cm_pkg::res_t      res_out
);
  import i2cm_pkg::*;

  logic valid_r;
  res_t res_r;

  // room when empty or the held result leaves this cycle
  assign can_load  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake            Carries
// in_      input      in_valid / in_stall  kind, data_byte, sda_level (one bus tick)
// out_     output     out_valid / out_stall pin levels, busy, read byte, status pulses
// cfg_     input      cfg_wr_en            half period ticks, ack poll limit
//
// One request is taken every cycle while in_stall is low; its result goes to the
// output register; sequencer state updates in the same cycle the request is taken.
// Synchronous active-low reset: bus idle (SCL and SDA high, released), no command.
// in_stall rises only while a result is held and out_stall is high.
module i2c_master_byte_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [2:0]                    in_kind,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_sda_level,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_scl_level,
  output logic                               out_sda_value,
  output logic                               out_sda_drive,
  output logic                               out_busy_res,
  output logic [7:0]                         out_read_data,
  output logic                               out_read_done,
  output logic                               out_ack_received,
  output logic                               out_ack_timeout,
  output logic                               out_command_dropped,
  input  wire logic                          cfg_wr_en,
  input  wire logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [i2cm_pkg::CfgDataW-1:0] cfg_wdata
);
  import i2cm_pkg::*;

  logic [HalfPeriodW-1:0] half_period_r;
  logic [PollW-1:0]       poll_limit_r;
  logic                   can_load;
  logic                   accept;
  res_t                   res_comb;
  res_t                   res_q;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      poll_limit_r  <= POLL_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_r <= cfg_wdata[HalfPeriodW-1:0];
        CFG_POLL_LIMIT:  poll_limit_r  <= cfg_wdata[PollW-1:0];
        default: ;
      endcase
    end
  end

  i2cm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance_en  (accept),
    .kind        (in_kind),
    .data_byte   (in_data_byte),
    .sda_level   (in_sda_level),
    .half_period (half_period_r),
    .poll_limit  (poll_limit_r),
    .res         (res_comb)
  );

  i2cm_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res_in    (res_comb),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res_out   (res_q)
  );

  assign out_scl_level       = res_q.scl_level;
  assign out_sda_value       = res_q.sda_value;
  assign out_sda_drive       = res_q.sda_drive;
  assign out_busy_res        = res_q.busy_res;
  assign out_read_data       = res_q.read_data;
  assign out_read_done       = res_q.read_done;
  assign out_ack_received    = res_q.ack_received;
  assign out_ack_timeout     = res_q.ack_timeout;
  assign out_command_dropped = res_q.command_dropped;

endmodule
`default_nettype wire
